>>> src/plas_pkg.sv
package plas_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int SINE_DEPTH_DEF = 256;

  localparam int FIELD_BITS = 12;
  localparam int PHASE_BITS = 16;
  localparam int GREY_BITS = 8;
  localparam int ANGLE_BITS = 16;
  localparam int IN_TDATA_BITS = 40;
  localparam int SINE_BITS = 15;

  localparam logic [63:0] PI_Q29 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // taylor series divisors (2k)(2k+1)
  localparam logic [63:0] SER_DIV_7 = 64'd210;
  localparam logic [63:0] SER_DIV_6 = 64'd156;
  localparam logic [63:0] SER_DIV_5 = 64'd110;
  localparam logic [63:0] SER_DIV_4 = 64'd72;
  localparam logic [63:0] SER_DIV_3 = 64'd42;
  localparam logic [63:0] SER_DIV_2 = 64'd20;
  localparam logic [63:0] SER_DIV_1 = 64'd6;

  // turns per radian over the divisor, Q0.32
  localparam int KW = 28;
  localparam logic [KW-1:0] K_4 =
    KW'(((64'd1 << 60) + (64'd4 * PI_Q29) / 64'd2) / (64'd4 * PI_Q29));
  localparam logic [KW-1:0] K_5 =
    KW'(((64'd1 << 60) + (64'd5 * PI_Q29) / 64'd2) / (64'd5 * PI_Q29));
  localparam logic [KW-1:0] K_6 =
    KW'(((64'd1 << 60) + (64'd6 * PI_Q29) / 64'd2) / (64'd6 * PI_Q29));
  localparam logic [KW-1:0] K_7 =
    KW'(((64'd1 << 60) + (64'd7 * PI_Q29) / 64'd2) / (64'd7 * PI_Q29));

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [ANGLE_BITS-1:0] ang3;
    logic [ANGLE_BITS-1:0] ang2;
    logic [ANGLE_BITS-1:0] ang1;
  } angle_set_t;

  // sine of theta (Q.30 radians, up to pi/2) in Q1.15, evaluated at elaboration
  function automatic logic [SINE_BITS-1:0] sine_entry(logic [63:0] theta);
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] q;
    x2 = (theta * theta) >> 30;
    r = ONE_Q30;
    r = ONE_Q30 - ((x2 * r) >> 30) / SER_DIV_7;
    r = ONE_Q30 - ((x2 * r) >> 30) / SER_DIV_6;
    r = ONE_Q30 - ((x2 * r) >> 30) / SER_DIV_5;
    r = ONE_Q30 - ((x2 * r) >> 30) / SER_DIV_4;
    r = ONE_Q30 - ((x2 * r) >> 30) / SER_DIV_3;
    r = ONE_Q30 - ((x2 * r) >> 30) / SER_DIV_2;
    r = ONE_Q30 - ((x2 * r) >> 30) / SER_DIV_1;
    s = (theta * r) >> 30;
    q = (s + (64'd1 << 14)) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[SINE_BITS-1:0];
  endfunction

endpackage

>>> src/plas_root_cell.sv
module plas_root_cell #(
  parameter int ROOT_BITS = 21
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [ROOT_BITS+1:0]       up_rem,
  input  logic [ROOT_BITS-1:0]       up_root,
  input  logic [2*ROOT_BITS-1:0]     up_rad,
  input  plas_pkg::angle_set_t       up_pay,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [ROOT_BITS+1:0]       dn_rem,
  output logic [ROOT_BITS-1:0]       dn_root,
  output logic [2*ROOT_BITS-1:0]     dn_rad,
  output plas_pkg::angle_set_t       dn_pay
);
  import plas_pkg::*;

  localparam int RW = ROOT_BITS + 2;
  localparam int VW = 2 * ROOT_BITS;

  logic             valid_r;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [VW-1:0]    rad_r, rad_nxt;
  angle_set_t       pay_r;

  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;
  logic             fits;

  // one root bit per cell
  always_comb begin
    rem_sh = {up_rem, up_rad[VW-1 -: 2]};
    trial = (RW+2)'({up_root, 2'b01});
    fits = (rem_sh >= trial);
    rem_nxt = fits ? RW'(rem_sh - trial) : RW'(rem_sh);
    root_nxt = {up_root[ROOT_BITS-2:0], fits};
    rad_nxt = up_rad << 2;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
      rad_r <= rad_nxt;
      pay_r <= up_pay;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem = rem_r;
  assign dn_root = root_r;
  assign dn_rad = rad_r;
  assign dn_pay = pay_r;

endmodule

>>> src/plas_sine_lookup.sv
module plas_sine_lookup #(
  parameter int SINE_TABLE_DEPTH = plas_pkg::SINE_DEPTH_DEF
) (
  input  logic [plas_pkg::ANGLE_BITS-1:0] angle,
  output logic signed [15:0]              sine
);
  import plas_pkg::*;

  localparam int IDXW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 14 + IDXW;

  logic [SINE_BITS-1:0] rom [SINE_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] THETA = (PI_Q29 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
    assign rom[gi] = sine_entry(THETA);
  end

  logic [1:0]      quad;
  logic [13:0]     rem;
  logic [PW-1:0]   scaled;
  logic [IDXW-1:0] idx_raw;
  logic [IDXW-1:0] idx_clip;
  logic [IDXW-1:0] idx;
  logic signed [15:0] mag;

  always_comb begin
    quad = angle[15:14];
    rem = angle[13:0];
    scaled = PW'(rem) * PW'(SINE_TABLE_DEPTH) + PW'(14'h2000);
    idx_raw = scaled[PW-1:14];
    idx_clip = (idx_raw > IDXW'(SINE_TABLE_DEPTH)) ? IDXW'(SINE_TABLE_DEPTH) : idx_raw;
    idx = quad[0] ? (IDXW'(SINE_TABLE_DEPTH) - idx_clip) : idx_clip;
    mag = {1'b0, rom[idx]};
    sine = quad[1] ? -mag : mag;
  end

endmodule

>>> src/plasma_pixel_generator_unit.sv
// path from input request to result: stage 0, stage 1, the root chain cells, then stages 2 to 5
// throughput: one pixel per cycle, back to back unless out_tready stalls, held by the square-root cell chain
// the root chain has one cell per root bit, each cell a single compare and subtract
// reset: synchronous active-low rst_n clears all stage valid flags; data regs keep values
// sine tables are constant logic, so no fill pass follows reset
module plasma_pixel_generator_unit #(
  parameter int COORD_BITS = plas_pkg::COORD_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = plas_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pixel_x[11:0], pixel_y[23:12], phase[39:24]
  input  logic [plas_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // grey_level[7:0]
  output logic [plas_pkg::GREY_BITS-1:0]      out_tdata
);
  import plas_pkg::*;

  localparam int CW = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int ROOT_BITS = CW + 9;
  localparam int RW = ROOT_BITS + 2;
  localparam int VW = 2 * ROOT_BITS;
  localparam int SQW = 2 * CW + 1;
  localparam int PRW = ROOT_BITS + KW;

  function automatic logic [ANGLE_BITS-1:0] round_turn(logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h0000_8000;
    return s[31:16];
  endfunction

  // stage 0: input register
  logic                   s0_valid_r;
  logic [CW-1:0]          s0_x_r;
  logic [CW-1:0]          s0_y_r;
  logic [PHASE_BITS-1:0]  s0_t_r;
  logic                   s0_ready;

  // stage 1: radicand and linear angles
  logic                   s1_valid_r;
  logic [VW-1:0]          s1_rad_r, s1_rad_nxt;
  angle_set_t             s1_pay_r, s1_pay_nxt;
  logic                   s1_ready;

  // root chain
  logic [ROOT_BITS:0]     c_valid;
  logic [ROOT_BITS:0]     c_ready;
  logic [RW-1:0]          c_rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]   c_root [ROOT_BITS+1];
  logic [VW-1:0]          c_rad  [ROOT_BITS+1];
  angle_set_t             c_pay  [ROOT_BITS+1];

  // stage 2: radial product
  logic                   s2_valid_r;
  logic [PRW-1:0]         s2_prod_r, s2_prod_nxt;
  angle_set_t             s2_pay_r;
  logic                   s2_ready;

  // stage 3: radial angle
  logic                   s3_valid_r;
  logic [ANGLE_BITS-1:0]  s3_ang4_r, s3_ang4_nxt;
  angle_set_t             s3_pay_r;
  logic                   s3_ready;

  // stage 4: sines
  logic                   s4_valid_r;
  logic signed [15:0]     s4_sin_r [4];
  logic signed [15:0]     s4_sin_nxt [4];
  logic                   s4_ready;

  // stage 5: output register
  logic                   s5_valid_r;
  logic [GREY_BITS-1:0]   s5_grey_r, s5_grey_nxt;
  logic                   s5_ready;

  logic [31:0]            t32;
  logic [SQW-1:0]         sq_sum;
  logic [CW+KW-1:0]       m1;
  logic [CW+KW-1:0]       m2;
  logic [CW+KW:0]         m3;
  logic [PRW:0]           prod_rnd;
  logic [31:0]            a4_raw;
  logic signed [17:0]     sin_sum;
  logic signed [27:0]     num;

  assign s5_ready = !s5_valid_r || out_tready;
  assign s4_ready = !s4_valid_r || s5_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || c_ready[0];
  assign s0_ready = !s0_valid_r || s1_ready;
  assign in_tready = s0_ready;

  always_comb begin
    t32 = {s0_t_r, 16'h0000};
    sq_sum = SQW'(s0_x_r * s0_x_r) + SQW'(s0_y_r * s0_y_r);
    s1_rad_nxt = VW'(sq_sum) << 16;
    m1 = (CW+KW)'(s0_x_r) * (CW+KW)'(K_7);
    m2 = (CW+KW)'(s0_y_r) * (CW+KW)'(K_5);
    m3 = ((CW+KW+1)'(s0_x_r) + (CW+KW+1)'(s0_y_r)) * (CW+KW+1)'(K_6);
    s1_pay_nxt.phase = s0_t_r;
    s1_pay_nxt.ang1 = round_turn(32'(m1) + t32);
    s1_pay_nxt.ang2 = round_turn(32'(m2) - t32);
    s1_pay_nxt.ang3 = round_turn(32'(m3) - t32);
  end

  always_comb begin
    s2_prod_nxt = PRW'(c_root[ROOT_BITS]) * PRW'(K_4);
    prod_rnd = {1'b0, s2_prod_r} + (PRW+1)'(8'd128);
    a4_raw = 32'(prod_rnd >> 8) - {s2_pay_r.phase, 16'h0000};
    s3_ang4_nxt = round_turn(a4_raw);
  end

  plas_sine_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin1 (
    .angle(s3_pay_r.ang1), .sine(s4_sin_nxt[0])
  );
  plas_sine_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin2 (
    .angle(s3_pay_r.ang2), .sine(s4_sin_nxt[1])
  );
  plas_sine_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin3 (
    .angle(s3_pay_r.ang3), .sine(s4_sin_nxt[2])
  );
  plas_sine_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin4 (
    .angle(s3_ang4_r), .sine(s4_sin_nxt[3])
  );

  always_comb begin
    sin_sum = 18'(s4_sin_r[0]) + 18'(s4_sin_r[1]) + 18'(s4_sin_r[2]) + 18'(s4_sin_r[3]);
    num = 28'sd16646144 + 28'(sin_sum) * 28'sd127;
    s5_grey_nxt = num[24:17];
  end

  // chain head
  assign c_valid[0] = s1_valid_r;
  assign c_rem[0] = '0;
  assign c_root[0] = '0;
  assign c_rad[0] = s1_rad_r;
  assign c_pay[0] = s1_pay_r;
  assign c_ready[ROOT_BITS] = s2_ready;

  for (genvar gc = 0; gc < ROOT_BITS; gc++) begin : g_cell
    plas_root_cell #(.ROOT_BITS(ROOT_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[gc]),
      .up_ready (c_ready[gc]),
      .up_rem   (c_rem[gc]),
      .up_root  (c_root[gc]),
      .up_rad   (c_rad[gc]),
      .up_pay   (c_pay[gc]),
      .dn_valid (c_valid[gc+1]),
      .dn_ready (c_ready[gc+1]),
      .dn_rem   (c_rem[gc+1]),
      .dn_root  (c_root[gc+1]),
      .dn_rad   (c_rad[gc+1]),
      .dn_pay   (c_pay[gc+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_tvalid;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
      if (s2_ready) begin
        s2_valid_r <= c_valid[ROOT_BITS];
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s4_ready) begin
        s4_valid_r <= s3_valid_r;
      end
      if (s5_ready) begin
        s5_valid_r <= s4_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready) begin
      s0_x_r <= in_tdata[CW-1:0];
      s0_y_r <= in_tdata[FIELD_BITS +: CW];
      s0_t_r <= in_tdata[2*FIELD_BITS +: PHASE_BITS];
    end
    if (s1_ready) begin
      s1_rad_r <= s1_rad_nxt;
      s1_pay_r <= s1_pay_nxt;
    end
    if (s2_ready) begin
      s2_prod_r <= s2_prod_nxt;
      s2_pay_r <= c_pay[ROOT_BITS];
    end
    if (s3_ready) begin
      s3_ang4_r <= s3_ang4_nxt;
      s3_pay_r <= s2_pay_r;
    end
    if (s4_ready) begin
      s4_sin_r <= s4_sin_nxt;
    end
    if (s5_ready) begin
      s5_grey_r <= s5_grey_nxt;
    end
  end

  assign out_tvalid = s5_valid_r;
  assign out_tdata = s5_grey_r;

  logic [ROOT_BITS+5:0] occ;
  assign occ = {s5_valid_r, s4_valid_r, s3_valid_r, s2_valid_r,
                c_valid[ROOT_BITS:1], s1_valid_r, s0_valid_r};

  a_occ_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !(out_tvalid && out_tready))
    |=> ($countones(occ) == $past($countones(occ)) + 1))
    else $error("pipeline occupancy did not grow on a lone input request");

  a_occ_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_tvalid && in_tready) && out_tvalid && out_tready)
    |=> ($countones(occ) == $past($countones(occ)) - 1))
    else $error("pipeline occupancy did not drop on a lone output request");

  a_grey_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= 8'd253))
    else $error("grey level above the reachable maximum");

  a_sine_range : assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> (s4_sin_r[0] != 16'sh8000 && s4_sin_r[1] != 16'sh8000 &&
                    s4_sin_r[2] != 16'sh8000 && s4_sin_r[3] != 16'sh8000))
    else $error("sine value outside Q1.15 table range");

endmodule
